@@ src/pgds_pkg.sv @@
`default_nettype none
package pgds_pkg;
  localparam int unsigned MAX_PARTICLES = 1024;
  localparam int unsigned ADDR_W = $clog2(MAX_PARTICLES);
  localparam int unsigned CNT_W = $clog2(MAX_PARTICLES + 1);
  localparam logic [31:0] GRAVITY_RESET = 32'd642908;
  localparam logic [30:0] DRAG_RESET = 31'd0;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_STEP = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FULL = 2'd1,
    ST_NOT_LIVE = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    CFG_GRAVITY = 1'd0,
    CFG_DRAG = 1'd1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_COEF1,
    S_COEF2,
    S_LOOP,
    S_RD,
    S_VEL1,
    S_VEL2,
    S_VEL3,
    S_POS1,
    S_POS2,
    S_WRITE,
    S_SWAPRD,
    S_SWAPWR,
    S_READ,
    S_DONE
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [48:0] x);
    if (x > 49'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -49'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction
endpackage
`default_nettype wire

@@ src/particle_gravity_drag_step.sv @@
// Particle table update. A step runs the coefficient states S_COEF1 and S_COEF2 and
// then, per live particle, one read, serial multiplies on the shared 32x32 multiplier
// and one write-back; an expired particle is swapped with the last one, and the swap
// states S_SWAPRD and S_SWAPWR stand in for the read of the moved entry. start is
// taken only while busy is low; each transaction ends with done high for one cycle,
// which the receiver cannot hold off.
`default_nettype none
module particle_gravity_drag_step (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  output logic        done,
  input  wire         cfg_we,
  input  wire  [0:0]  cfg_index,
  input  wire  [31:0] cfg_data,
  input  wire  [1:0]  operation,
  input  wire  [9:0]  index,
  input  wire  signed [31:0] pos_x,
  input  wire  signed [31:0] pos_y,
  input  wire  signed [31:0] pos_z,
  input  wire  signed [31:0] vel_x,
  input  wire  signed [31:0] vel_y,
  input  wire  signed [31:0] vel_z,
  input  wire  signed [31:0] life_left,
  input  wire  [15:0] time_step,
  output logic [1:0]  status,
  output logic [10:0] live_count,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic signed [31:0] out_vel_z,
  output logic signed [31:0] out_life
);
  localparam int unsigned AW = pgds_pkg::ADDR_W;
  localparam int unsigned CW = pgds_pkg::CNT_W;

  logic [223:0] mem [pgds_pkg::MAX_PARTICLES];
  logic [223:0] rdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [223:0] wdata;
  logic we;

  pgds_pkg::state_t state, state_next;
  logic signed [31:0] gravity;
  logic [30:0] drag;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [15:0] dt;
  logic signed [31:0] f, gs;
  logic signed [31:0] f_next, gs_next;
  logic signed [31:0] px, py, vx, vy, life;
  logic signed [31:0] px_next, py_next, vx_next, vy_next, life_next;
  logic [223:0] rec, rec_next;
  logic signed [223:0] in_rec;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic [1:0] status_next;
  logic done_next;
  logic [223:0] res, res_next;
  logic [1:0] status_r;

  // a..g: pos x,y,z, vel x,y,z, life
  assign in_rec = {life_left, vel_z, vel_y, vel_x, pos_z, pos_y, pos_x};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity <= pgds_pkg::GRAVITY_RESET;
      drag <= pgds_pkg::DRAG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pgds_pkg::CFG_GRAVITY: gravity <= cfg_data;
        pgds_pkg::CFG_DRAG: drag <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pgds_pkg::S_IDLE;
      count <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done <= done_next;
    end
    idx <= idx_next;
    f <= f_next;
    gs <= gs_next;
    px <= px_next;
    py <= py_next;
    vx <= vx_next;
    vy <= vy_next;
    life <= life_next;
    rec <= rec_next;
    res <= res_next;
    status_r <= status_next;
    if (start && !busy) begin
      dt <= time_step;
    end
  end

  logic signed [48:0] t49;
  logic signed [64:0] negp;
  logic signed [47:0] shp;

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next = idx;
    f_next = f;
    gs_next = gs;
    px_next = px;
    py_next = py;
    vx_next = vx;
    vy_next = vy;
    life_next = life;
    rec_next = rec;
    res_next = res;
    status_next = status_r;
    done_next = 1'b0;
    ma = '0;
    mb = '0;
    raddr = idx[AW-1:0];
    waddr = idx[AW-1:0];
    wdata = '0;
    we = 1'b0;
    t49 = '0;
    negp = '0;
    shp = prod[63:16];
    case (state)
      pgds_pkg::S_IDLE: begin
        if (start && !busy) begin
          res_next = '0;
          status_next = pgds_pkg::ST_OK;
          case (pgds_pkg::op_t'(operation))
            pgds_pkg::OP_APPEND: begin
              if (count >= CW'(pgds_pkg::MAX_PARTICLES)) begin
                status_next = pgds_pkg::ST_FULL;
              end else begin
                we = 1'b1;
                waddr = count[AW-1:0];
                wdata = in_rec;
                count_next = count + 1'b1;
              end
              state_next = pgds_pkg::S_DONE;
            end
            pgds_pkg::OP_STEP: state_next = pgds_pkg::S_COEF1;
            pgds_pkg::OP_READ: begin
              if (CW'(index) >= count) begin
                status_next = pgds_pkg::ST_NOT_LIVE;
                state_next = pgds_pkg::S_DONE;
              end else begin
                raddr = index[AW-1:0];
                state_next = pgds_pkg::S_READ;
              end
            end
            default: state_next = pgds_pkg::S_DONE;
          endcase
        end
      end
      pgds_pkg::S_READ: begin
        res_next = rdata;
        state_next = pgds_pkg::S_DONE;
      end
      pgds_pkg::S_COEF1: begin
        ma = {1'b0, drag};
        mb = {16'd0, dt};
        state_next = pgds_pkg::S_COEF2;
      end
      pgds_pkg::S_COEF2: begin
        // drag product is nonnegative and below 2^47
        t49 = 49'sd65536 - 49'(shp);
        f_next = (t49 < 0) ? '0 : t49[31:0];
        ma = gravity;
        mb = {16'd0, dt};
        idx_next = '0;
        state_next = pgds_pkg::S_LOOP;
      end
      pgds_pkg::S_LOOP: begin
        negp = -65'(prod);
        gs_next = (state == pgds_pkg::S_LOOP && idx == '0) ? 32'(negp >>> 16) : gs;
        if (idx >= count) begin
          state_next = pgds_pkg::S_DONE;
        end else begin
          raddr = idx[AW-1:0];
          state_next = pgds_pkg::S_RD;
        end
      end
      pgds_pkg::S_RD: begin
        px_next = rdata[31:0];
        py_next = rdata[63:32];
        rec_next = rdata;
        vx_next = rdata[127:96];
        vy_next = pgds_pkg::sat32(49'(signed'(rdata[159:128])) + 49'(gs));
        life_next = pgds_pkg::sat32(49'(signed'(rdata[223:192])) - 49'(dt));
        state_next = pgds_pkg::S_VEL1;
      end
      pgds_pkg::S_VEL1: begin
        ma = vx;
        mb = f;
        state_next = pgds_pkg::S_VEL2;
      end
      pgds_pkg::S_VEL2: begin
        vx_next = pgds_pkg::sat32(49'(shp));
        ma = vy;
        mb = f;
        state_next = pgds_pkg::S_VEL3;
      end
      pgds_pkg::S_VEL3: begin
        vy_next = pgds_pkg::sat32(49'(shp));
        ma = vx;
        mb = {16'd0, dt};
        state_next = pgds_pkg::S_POS1;
      end
      pgds_pkg::S_POS1: begin
        px_next = pgds_pkg::sat32(49'(px) + 49'(shp));
        ma = vy;
        mb = {16'd0, dt};
        state_next = pgds_pkg::S_POS2;
      end
      pgds_pkg::S_POS2: begin
        py_next = pgds_pkg::sat32(49'(py) + 49'(shp));
        state_next = pgds_pkg::S_WRITE;
      end
      pgds_pkg::S_WRITE: begin
        we = 1'b1;
        waddr = idx[AW-1:0];
        wdata = {life, 32'd0, vy, vx, rec[95:64], py, px};
        if (life < 0) begin
          count_next = count - 1'b1;
          rec_next = wdata;
          state_next = pgds_pkg::S_SWAPRD;
        end else begin
          idx_next = idx + 1'b1;
          state_next = pgds_pkg::S_LOOP;
        end
      end
      pgds_pkg::S_SWAPRD: begin
        raddr = count[AW-1:0];
        state_next = pgds_pkg::S_SWAPWR;
      end
      pgds_pkg::S_SWAPWR: begin
        // expired entry goes to the old last slot, last entry moves here
        we = 1'b1;
        waddr = count[AW-1:0];
        wdata = rec;
        px_next = rdata[31:0];
        py_next = rdata[63:32];
        rec_next = rdata;
        vx_next = rdata[127:96];
        vy_next = pgds_pkg::sat32(49'(signed'(rdata[159:128])) + 49'(gs));
        life_next = pgds_pkg::sat32(49'(signed'(rdata[223:192])) - 49'(dt));
        state_next = (idx >= count) ? pgds_pkg::S_DONE : pgds_pkg::S_VEL1;
      end
      pgds_pkg::S_DONE: begin
        done_next = 1'b1;
        state_next = pgds_pkg::S_IDLE;
      end
      default: state_next = pgds_pkg::S_IDLE;
    endcase
  end

  // the memory read of an entry just swapped is not needed: swapped entry comes via rdata
  assign busy = (state != pgds_pkg::S_IDLE) || done;
  assign status = done ? status_r : '0;
  assign live_count = 11'(count);
  assign out_pos_x = done ? res[31:0] : '0;
  assign out_pos_y = done ? res[63:32] : '0;
  assign out_pos_z = done ? res[95:64] : '0;
  assign out_vel_x = done ? res[127:96] : '0;
  assign out_vel_y = done ? res[159:128] : '0;
  assign out_vel_z = done ? res[191:160] : '0;
  assign out_life = done ? res[223:192] : '0;
endmodule
`default_nettype wire

@@ src/pgds_checker.sv @@
`default_nettype none
module pgds_checker (
  input wire clk,
  input wire rst,
  input wire start,
  input wire busy,
  input wire done,
  input wire [1:0] status,
  input wire [10:0] live_count
);
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted transaction not busy");
  a_one_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done longer than one cycle");
  a_count: assert property (@(posedge clk) disable iff (rst) live_count <= 11'd1024)
    else $error("count out of range");
  a_status: assert property (@(posedge clk) disable iff (rst) done |-> status != 2'd3)
    else $error("bad status");
endmodule
bind particle_gravity_drag_step pgds_checker u_pgds_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .live_count(live_count)
);
`default_nettype wire
